// File: rtl/mxdp_pkg.sv
// Shared types, constants and helper functions of the MXFP4 by BF16 dot product core.
`default_nettype none

package mxdp_pkg;

  // Number of elements that one item carries.
  localparam int unsigned DefLanes = 4;

  // Internal unpacked floating point format: value = sig * 2^(exp - 23).
  localparam int unsigned ExpW = 10;
  localparam int unsigned SigW = 24;
  localparam logic signed [ExpW-1:0] ExpMin  = 10'sh200;
  localparam logic signed [ExpW-1:0] ExpBias = 10'sd127;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;
  localparam logic [7:0]  ScaleInf = 8'hFF;

  typedef struct packed {
    logic                   nan;
    logic                   inf;
    logic                   zero;
    logic                   sign;
    logic signed [ExpW-1:0] exp;
    logic [SigW-1:0]        sig;
  } fp_t;

  // E2M1 magnitude times two: 0, 0.5, 1, 1.5, 2, 3, 4, 6.
  function automatic logic [3:0] e2m1_mag2(input logic [2:0] code);
    logic [3:0] m;
    case (code)
      3'd0:    m = 4'd0;
      3'd1:    m = 4'd1;
      3'd2:    m = 4'd2;
      3'd3:    m = 4'd3;
      3'd4:    m = 4'd4;
      3'd5:    m = 4'd6;
      3'd6:    m = 4'd8;
      default: m = 4'd12;
    endcase
    return m;
  endfunction

  // Unpack FP32 bits; subnormals keep exponent -126 with a leading zero.
  function automatic fp_t unpack_f32(input logic [31:0] bits);
    fp_t r;
    r.sign = bits[31];
    r.nan  = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
    r.inf  = (bits[30:23] == 8'hFF) && (bits[22:0] == 23'd0);
    r.zero = (bits[30:0] == 31'd0);
    if (bits[30:23] == 8'hFF || r.zero) begin
      r.exp = ExpMin;
      r.sig = '0;
    end else if (bits[30:23] == 8'd0) begin
      r.exp = -10'sd126;
      r.sig = {1'b0, bits[22:0]};
    end else begin
      r.exp = $signed({2'b00, bits[30:23]}) - ExpBias;
      r.sig = {1'b1, bits[22:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mxdp_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface mxdp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] act_a;
  logic [15:0] act_b;
  logic [15:0] act_c;
  logic [15:0] act_d;
  logic [15:0] weight_nibbles;
  logic [7:0]  scale_exp;
  logic        group_end;
  logic        row_end;

  modport source (
    output valid, act_a, act_b, act_c, act_d, weight_nibbles, scale_exp, group_end, row_end,
    input  ready
  );
  modport sink (
    input  valid, act_a, act_b, act_c, act_d, weight_nibbles, scale_exp, group_end, row_end,
    output ready
  );
endinterface

interface mxdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_sum;

  modport source (output valid, row_sum, input ready);
  modport sink (input valid, row_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/mxfp4_bf16_dot_product_core.sv
// MXFP4 weight by BF16 activation dot product core: one FP32 result per row.
//
// Input channel in_i carries one item: four BF16 activations, four packed E2M1
// weight codes, the E8M0 scale byte of the group and the group and row end flags.
// The first LANES elements are used. Output channel out_o carries the FP32 row sum,
// one item for every input item that has row_end set.
// The LANES products are formed side by side in the cycle of acceptance. They are
// then added in element order into the group sum through one two-stage FP32 adder,
// each lane passing an issue and a done state; closing a group adds an issue and
// a done state for the scaled row add, and a row end an emit state for the hand-over.
// The core takes no new item before it is through with the last: in_i.ready is high
// only while the core is free. The row sum is loaded into the output register from
// the emit state once that register is free.
// A finished sum sits in an output register, so a stalled receiver does not hold up
// the next row until its result is ready as well.
// Reset clears both sums to positive zero and empties the output register.
`default_nettype none

module mxfp4_bf16_dot_product_core #(
  parameter int unsigned LANES = mxdp_pkg::DefLanes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mxdp_in_if.sink           in_i,
  mxdp_out_if.source        out_o
);

  logic [15:0]   acts [4];
  mxdp_pkg::fp_t prods [LANES];
  logic          idle;
  logic          emit;
  logic          out_free;
  logic [31:0]   row_sum;

  assign acts[0] = in_i.act_a;
  assign acts[1] = in_i.act_b;
  assign acts[2] = in_i.act_c;
  assign acts[3] = in_i.act_d;

  // One product lane per element.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mxdp_lane u_lane (
      .act_i  (acts[g]),
      .code_i (in_i.weight_nibbles[4*g +: 4]),
      .prod_o (prods[g])
    );
  end

  assign in_i.ready = idle;

  mxdp_seq #(
    .LANES (LANES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid),
    .prod_i      (prods),
    .scale_exp_i (in_i.scale_exp),
    .group_end_i (in_i.group_end),
    .row_end_i   (in_i.row_end),
    .idle_o      (idle),
    .emit_o      (emit),
    .out_free_i  (out_free),
    .row_sum_o   (row_sum)
  );

  mxdp_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .data_i  (row_sum),
    .ready_i (out_o.ready),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .data_o  (out_o.row_sum)
  );

endmodule

`default_nettype wire

// File: rtl/mxdp_lane.sv
// One product lane: exact BF16 activation times E2M1 weight, normalised; subnormal activations flush to zero.
`default_nettype none

module mxdp_lane (
  input  logic [15:0]        act_i,
  input  logic [3:0]         code_i,
  output mxdp_pkg::fp_t      prod_o
);

  logic [7:0]        exp_f;
  logic [7:0]        sig8;
  logic [3:0]        mag2;
  logic [11:0]       prod;
  logic [3:0]        lz;
  logic [11:0]       prod_n;
  logic signed [9:0] e_lead;
  logic              a_flush;
  logic              a_inf;
  logic              a_nan;

  assign exp_f   = act_i[14:7];
  assign sig8    = {1'b1, act_i[6:0]};
  assign mag2    = mxdp_pkg::e2m1_mag2(code_i[2:0]);
  assign a_flush = (exp_f == 8'd0);
  assign a_inf   = (exp_f == 8'hFF) && (act_i[6:0] == 7'd0);
  assign a_nan   = (exp_f == 8'hFF) && (act_i[6:0] != 7'd0);

  // Exact integer product of the significand and twice the weight magnitude.
  assign prod = 12'(sig8 * mag2);

  // Leading zero count of the twelve bit product.
  always_comb begin
    lz = 4'd12;
    for (int i = 0; i < 12; i++) begin
      if (prod[i]) begin
        lz = 4'(11 - i);
      end
    end
  end

  assign prod_n = prod << lz;
  assign e_lead = $signed({2'b00, exp_f}) - 10'sd124 - $signed({6'b0, lz});

  // Classify the product and place it in the unpacked format.
  always_comb begin
    prod_o.sign = act_i[15] ^ code_i[3];
    prod_o.nan  = a_nan || (a_inf && mag2 == 4'd0);
    prod_o.inf  = !prod_o.nan && (a_inf || (!a_flush && mag2 != 4'd0 && e_lead > 10'sd127));
    prod_o.zero = !prod_o.nan && !a_inf && (a_flush || mag2 == 4'd0);
    if (prod_o.zero || prod_o.nan || prod_o.inf) begin
      prod_o.exp = mxdp_pkg::ExpMin;
      prod_o.sig = '0;
    end else begin
      prod_o.exp = e_lead;
      prod_o.sig = {prod_n, 12'd0};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mxdp_fadd.sv
// Two stage FP32 adder with one rounding: align and add, then normalise and round.
`default_nettype none

module mxdp_fadd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mxdp_pkg::fp_t op_a_i,
  input  mxdp_pkg::fp_t op_b_i,
  output logic [31:0]   sum_o
);

  localparam int unsigned FieldW = 51;

  typedef struct packed {
    logic                  nan;
    logic                  inf;
    logic                  inf_sign;
    logic                  both_zero;
    logic                  zero_sign;
    logic                  sign;
    logic signed [9:0]     exp;
    logic [FieldW-1:0]     mag;
    logic                  sticky;
  } add_st_t;

  add_st_t st_d, st_q;

  mxdp_pkg::fp_t     big;
  mxdp_pkg::fp_t     sml;
  logic signed [10:0] dexp;
  logic [5:0]        shamt;
  logic [FieldW-1:0] fa, fb_full, fb;
  logic              st1;
  logic [FieldW:0]   diff;

  // Stage one: align the smaller exponent operand and add or subtract.
  always_comb begin
    if (op_a_i.exp >= op_b_i.exp) begin
      big = op_a_i;
      sml = op_b_i;
    end else begin
      big = op_b_i;
      sml = op_a_i;
    end
    dexp    = $signed({big.exp[9], big.exp}) - $signed({sml.exp[9], sml.exp});
    shamt   = (dexp > 11'sd63) ? 6'd63 : dexp[5:0];
    fa      = {1'b0, big.sig, 26'd0};
    fb_full = {1'b0, sml.sig, 26'd0};
    fb      = fb_full >> shamt;
    st1     = |(fb_full & ~({FieldW{1'b1}} << shamt));
    diff    = {1'b0, fa} - {1'b0, fb};

    st_d.exp    = big.exp;
    st_d.sticky = st1;
    if (big.sign == sml.sign) begin
      st_d.mag  = fa + fb;
      st_d.sign = big.sign;
    end else if (!diff[FieldW] && (diff[FieldW-1:0] != '0 || !st1)) begin
      st_d.mag  = diff[FieldW-1:0] - FieldW'(st1);
      st_d.sign = big.sign;
    end else begin
      st_d.mag  = fb - fa;
      st_d.sign = sml.sign;
    end

    st_d.nan       = op_a_i.nan || op_b_i.nan ||
                     (op_a_i.inf && op_b_i.inf && op_a_i.sign != op_b_i.sign);
    st_d.inf       = op_a_i.inf || op_b_i.inf;
    st_d.inf_sign  = op_a_i.inf ? op_a_i.sign : op_b_i.sign;
    st_d.both_zero = op_a_i.zero && op_b_i.zero;
    st_d.zero_sign = op_a_i.sign && op_b_i.sign;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  logic [5:0]        lz;
  logic signed [11:0] e_lead;
  logic signed [11:0] sh_sub;
  logic [11:0]       r_amt;
  logic [5:0]        r_sh;
  logic [FieldW-1:0] norm;
  logic              st_out;
  logic              sticky2;
  logic [23:0]       top;
  logic              guard;
  logic              up;
  logic [7:0]        biased;
  logic [31:0]       packed_r;

  // Leading zero count of the raw sum.
  always_comb begin
    lz = 6'(FieldW);
    for (int i = 0; i < FieldW; i++) begin
      if (st_q.mag[i]) begin
        lz = 6'(FieldW - 1 - i);
      end
    end
  end

  // Stage two: normalise, or denormalise below the FP32 normal range, then round.
  always_comb begin
    e_lead = $signed({{2{st_q.exp[9]}}, st_q.exp}) + 12'sd1 - $signed({6'd0, lz});
    sh_sub = $signed({6'd0, lz}) + e_lead + 12'sd126;
    r_amt  = 12'(-sh_sub);
    r_sh   = (r_amt > 12'd63) ? 6'd63 : r_amt[5:0];
    if (e_lead >= -12'sd126) begin
      norm   = st_q.mag << lz;
      st_out = 1'b0;
    end else if (sh_sub >= 12'sd0) begin
      norm   = st_q.mag << sh_sub[5:0];
      st_out = 1'b0;
    end else begin
      norm   = st_q.mag >> r_sh;
      st_out = |(st_q.mag & ~({FieldW{1'b1}} << r_sh));
    end
    top      = norm[FieldW-1:FieldW-24];
    guard    = norm[FieldW-25];
    sticky2  = st_q.sticky || st_out || (norm[FieldW-26:0] != '0);
    up       = guard && (sticky2 || top[0]);
    biased   = top[23] ? 8'(e_lead + 12'sd127) : 8'd0;
    packed_r = {1'b0, biased, top[22:0]} + 32'(up);

    if (st_q.nan) begin
      sum_o = mxdp_pkg::CanonNan;
    end else if (st_q.inf) begin
      sum_o = {st_q.inf_sign, mxdp_pkg::InfMag};
    end else if (st_q.both_zero) begin
      sum_o = {st_q.zero_sign, 31'd0};
    end else if (st_q.mag == '0 && !st_q.sticky) begin
      sum_o = 32'd0;
    end else if (e_lead > 12'sd127) begin
      sum_o = {st_q.sign, mxdp_pkg::InfMag};
    end else begin
      sum_o = {st_q.sign, packed_r[30:0]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mxdp_seq.sv
// Merging stage: feeds the lane products one by one through the adder into the sums.
`default_nettype none

module mxdp_seq #(
  parameter int unsigned LANES = mxdp_pkg::DefLanes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mxdp_pkg::fp_t prod_i [LANES],
  input  logic [7:0]    scale_exp_i,
  input  logic          group_end_i,
  input  logic          row_end_i,
  output logic          idle_o,
  output logic          emit_o,
  input  logic          out_free_i,
  output logic [31:0]   row_sum_o
);

  localparam int unsigned IdxW = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [5:0] {
    S_IDLE        = 6'b000001,
    S_ADD_ISSUE   = 6'b000010,
    S_ADD_DONE    = 6'b000100,
    S_CLOSE_ISSUE = 6'b001000,
    S_CLOSE_DONE  = 6'b010000,
    S_EMIT        = 6'b100000
  } state_e;

  state_e            state_d, state_q;
  logic [IdxW-1:0]   k_d, k_q;
  mxdp_pkg::fp_t     prod_q [LANES];
  logic [7:0]        scale_q;
  logic              close_q;
  logic              rend_q;
  logic [31:0]       gs_d, gs_q;
  logic [31:0]       row_d, row_q;
  logic [31:0]       sum;
  mxdp_pkg::fp_t     op_a, op_b;
  mxdp_pkg::fp_t     gs_u, scaled;
  logic              last;

  assign last = (k_q == IdxW'(LANES - 1));

  // Group sum scaled by two to the (scale minus 127); scale byte 255 is infinity.
  always_comb begin
    gs_u        = mxdp_pkg::unpack_f32(gs_q);
    scaled      = gs_u;
    scaled.nan  = gs_u.nan || (scale_q == mxdp_pkg::ScaleInf && gs_u.zero);
    scaled.inf  = !scaled.nan && (gs_u.inf || scale_q == mxdp_pkg::ScaleInf);
    scaled.zero = gs_u.zero && !scaled.nan && !scaled.inf;
    if (!gs_u.zero && !gs_u.nan && !gs_u.inf) begin
      scaled.exp = gs_u.exp + $signed({2'b00, scale_q}) - mxdp_pkg::ExpBias;
    end
  end

  // Adder operands: group add in the lane phase, row add at group close.
  always_comb begin
    if (state_q == S_CLOSE_ISSUE) begin
      op_a = mxdp_pkg::unpack_f32(row_q);
      op_b = scaled;
    end else begin
      op_a = gs_u;
      op_b = prod_q[k_q];
    end
  end

  mxdp_fadd u_fadd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sum_o  (sum)
  );

  // Sequencer over the lanes, the group close and the result hand-off.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    gs_d    = gs_q;
    row_d   = row_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          k_d     = '0;
          state_d = S_ADD_ISSUE;
        end
      end
      S_ADD_ISSUE: begin
        state_d = S_ADD_DONE;
      end
      S_ADD_DONE: begin
        gs_d = sum;
        if (last) begin
          state_d = close_q ? S_CLOSE_ISSUE : S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_ADD_ISSUE;
        end
      end
      S_CLOSE_ISSUE: begin
        state_d = S_CLOSE_DONE;
      end
      S_CLOSE_DONE: begin
        row_d   = sum;
        gs_d    = 32'd0;
        state_d = rend_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free_i) begin
          row_d   = 32'd0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o    = (state_q == S_IDLE);
  assign emit_o    = (state_q == S_EMIT) && out_free_i;
  assign row_sum_o = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      gs_q    <= 32'd0;
      row_q   <= 32'd0;
      close_q <= 1'b0;
      rend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      gs_q    <= gs_d;
      row_q   <= row_d;
      if (start_i && state_q == S_IDLE) begin
        close_q <= group_end_i || row_end_i;
        rend_q  <= row_end_i;
      end
    end
  end

  // Item payload held while the lanes are merged.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) begin
      prod_q  <= prod_i;
      scale_q <= scale_exp_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mxdp_ram_dummy_placeholder.sv
// Result output register stage holding one finished row sum until it is taken.
`default_nettype none

module mxdp_outreg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] data_i,
  input  logic        ready_i,
  output logic        free_o,
  output logic        valid_o,
  output logic [31:0] data_o
);

  logic        valid_q;
  logic [31:0] data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire
